// File: rtl/core/ac8_pkg.sv
// Shared types, codes and constants of the 8-bit accumulator CPU.
package ac8_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 11;

    // Request operation codes.
    typedef logic [1:0] req_op_t;
    localparam req_op_t OP_MEM_WR = 2'd0;
    localparam req_op_t OP_MEM_RD = 2'd1;
    localparam req_op_t OP_IO_RD  = 2'd2;
    localparam req_op_t OP_EXEC   = 2'd3;

    // Instruction opcodes (top five bits of the instruction word).
    typedef logic [4:0] opcode_t;
    localparam opcode_t OPC_WM   = 5'h01;
    localparam opcode_t OPC_RM   = 5'h02;
    localparam opcode_t OPC_BR   = 5'h03;
    localparam opcode_t OPC_RIO  = 5'h04;
    localparam opcode_t OPC_WIO  = 5'h05;
    localparam opcode_t OPC_WB   = 5'h06;
    localparam opcode_t OPC_WIB  = 5'h07;
    localparam opcode_t OPC_WACC = 5'h09;
    localparam opcode_t OPC_RACC = 5'h0B;
    localparam opcode_t OPC_SWAP = 5'h0E;
    localparam opcode_t OPC_BRLT = 5'h11;
    localparam opcode_t OPC_BRGT = 5'h12;
    localparam opcode_t OPC_BRNE = 5'h13;
    localparam opcode_t OPC_BRE  = 5'h14;
    localparam opcode_t OPC_SHR  = 5'h15;
    localparam opcode_t OPC_SHL  = 5'h16;
    localparam opcode_t OPC_XOR  = 5'h17;
    localparam opcode_t OPC_NOT  = 5'h18;
    localparam opcode_t OPC_OR   = 5'h19;
    localparam opcode_t OPC_AND  = 5'h1A;
    localparam opcode_t OPC_MUL  = 5'h1B;
    localparam opcode_t OPC_SUB  = 5'h1D;
    localparam opcode_t OPC_ADD  = 5'h1E;
    localparam opcode_t OPC_EOP  = 5'h1F;

    // Bit positions in the flag byte.
    localparam int FLAG_Z = 0;
    localparam int FLAG_C = 1;
    localparam int FLAG_S = 2;
    localparam int FLAG_O = 7;

    // Main memory address source.
    typedef enum logic [2:0] {
        ADDR_PC      = 3'd0,
        ADDR_PC_INC  = 3'd1,
        ADDR_OPERAND = 3'd2,
        ADDR_REQ     = 3'd3,
        ADDR_CLEAR   = 3'd4
    } ram_addr_sel_t;

    // Main memory write data source.
    typedef enum logic [1:0] {
        WDATA_REQ  = 2'd0,
        WDATA_MBR  = 2'd1,
        WDATA_ZERO = 2'd2
    } wdata_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          accept;
        logic          ram_en;
        logic          ram_we;
        ram_addr_sel_t addr_sel;
        wdata_sel_t    wdata_sel;
        logic          clear_step;
        logic          ir_hi_load;
        logic          exec;
        logic          mbr_load_ram;
        logic          rd_load;
        logic          out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    halted;
        opcode_t opcode;
        logic    clear_last;
    } dp_status_t;

endpackage

// File: rtl/core/ac8_stream_if.sv
// Request and response channel interfaces of the 8-bit accumulator CPU.
interface ac8_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [ac8_pkg::ADDR_W-1:0]    address;
    logic [ac8_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output operation, output address, output data, input ready);
    modport sink (input valid, input operation, input address, input data, output ready);
endinterface

interface ac8_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ac8_pkg::BYTE_W-1:0]    read_data;
    logic [ac8_pkg::ADDR_W-1:0]    program_counter;
    logic [ac8_pkg::BYTE_W-1:0]    accumulator;
    logic [ac8_pkg::BYTE_W-1:0]    memory_buffer;
    logic [ac8_pkg::BYTE_W-1:0]    io_buffer_reg;
    logic [ac8_pkg::BYTE_W-1:0]    flag_bits;
    logic                          halted;

    modport source (
        output valid, output read_data, output program_counter, output accumulator,
        output memory_buffer, output io_buffer_reg, output flag_bits, output halted,
        input ready
    );
    modport sink (
        input valid, input read_data, input program_counter, input accumulator,
        input memory_buffer, input io_buffer_reg, input flag_bits, input halted,
        output ready
    );
endinterface

// File: rtl/core/accumulator_cpu_8bit.sv
// Top level of the 8-bit accumulator CPU with internal main memory and I/O store.
//
// Usage: each request transaction on req carries an operation, an address and a
// data byte: write a memory byte, read a memory byte, read an I/O byte, or
// execute one instruction at PC. Every request gives exactly one response
// transaction on rsp with the read byte (zero for writes and executes) and the
// register values PC, ACC, MBR, IOBR, flags and halted after the request.
// Requests are taken one at a time. An I/O read or a halted execute goes
// straight to the response state; a memory write first passes a write state,
// a memory read a read and a wait state, an execute two fetch states and an
// execute state, and an execute of RM also a load state. The sequencer sets
// these steps: the single-port main memory gives one access per cycle and an
// execute needs two fetch reads plus at most one data access. The next
// request can be accepted in the cycle after the previous result is loaded.
// The response sits in a result register: while the receiver stalls, the block
// still accepts and works on one further request and holds its result until
// the register frees. After reset the block sweeps the main memory to zero,
// with req.ready low; the registers and the I/O store clear at once.
module accumulator_cpu_8bit #(
    parameter int MEM_ADDR_BITS = 11,
    parameter int IO_DEPTH      = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    ac8_req_if.sink          req,
    ac8_rsp_if.source        rsp
);

    ac8_pkg::dp_cmd_t    cmd;
    ac8_pkg::dp_status_t status;

    ac8_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .status        (status),
        .cmd           (cmd)
    );

    ac8_datapath #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .IO_DEPTH      (IO_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_operation   (req.operation),
        .req_address     (req.address),
        .req_data        (req.data),
        .cmd             (cmd),
        .status          (status),
        .read_data       (rsp.read_data),
        .program_counter (rsp.program_counter),
        .accumulator     (rsp.accumulator),
        .memory_buffer   (rsp.memory_buffer),
        .io_buffer_reg   (rsp.io_buffer_reg),
        .flag_bits       (rsp.flag_bits),
        .halted          (rsp.halted)
    );

endmodule

// File: rtl/core/ac8_ram.sv
// Generic single-port RAM with registered read data.
module ac8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: a write, or a read whose data appears next cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: rtl/core/ac8_ctrl.sv
// Controller state machine of the 8-bit accumulator CPU.
module ac8_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_operation,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  ac8_pkg::dp_status_t status,
    output ac8_pkg::dp_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_MEM_WR   = 10'b00_0000_0100,
        ST_MEM_RD   = 10'b00_0000_1000,
        ST_RD_WAIT  = 10'b00_0001_0000,
        ST_FETCH_HI = 10'b00_0010_0000,
        ST_FETCH_LO = 10'b00_0100_0000,
        ST_EXEC     = 10'b00_1000_0000,
        ST_LOAD_WB  = 10'b01_0000_0000,
        ST_RESP     = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.ram_en     = 1'b1;
                cmd.ram_we     = 1'b1;
                cmd.addr_sel   = ac8_pkg::ADDR_CLEAR;
                cmd.wdata_sel  = ac8_pkg::WDATA_ZERO;
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (req_operation)
                        ac8_pkg::OP_MEM_WR: state_next = ST_MEM_WR;
                        ac8_pkg::OP_MEM_RD: state_next = ST_MEM_RD;
                        ac8_pkg::OP_IO_RD:  state_next = ST_RESP;
                        default:            state_next = status.halted ? ST_RESP : ST_FETCH_HI;
                    endcase
                end
            end
            ST_MEM_WR:
            begin
                cmd.ram_en    = 1'b1;
                cmd.ram_we    = 1'b1;
                cmd.addr_sel  = ac8_pkg::ADDR_REQ;
                cmd.wdata_sel = ac8_pkg::WDATA_REQ;
                state_next    = ST_RESP;
            end
            ST_MEM_RD:
            begin
                cmd.ram_en   = 1'b1;
                cmd.addr_sel = ac8_pkg::ADDR_REQ;
                state_next   = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                cmd.rd_load = 1'b1;
                state_next  = ST_RESP;
            end
            ST_FETCH_HI:
            begin
                cmd.ram_en   = 1'b1;
                cmd.addr_sel = ac8_pkg::ADDR_PC;
                state_next   = ST_FETCH_LO;
            end
            ST_FETCH_LO:
            begin
                cmd.ram_en     = 1'b1;
                cmd.addr_sel   = ac8_pkg::ADDR_PC_INC;
                cmd.ir_hi_load = 1'b1;
                state_next     = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
                if (status.opcode == ac8_pkg::OPC_WM)
                begin
                    cmd.ram_en    = 1'b1;
                    cmd.ram_we    = 1'b1;
                    cmd.addr_sel  = ac8_pkg::ADDR_OPERAND;
                    cmd.wdata_sel = ac8_pkg::WDATA_MBR;
                end
                else if (status.opcode == ac8_pkg::OPC_RM)
                begin
                    cmd.ram_en   = 1'b1;
                    cmd.addr_sel = ac8_pkg::ADDR_OPERAND;
                    state_next   = ST_LOAD_WB;
                end
            end
            ST_LOAD_WB:
            begin
                cmd.mbr_load_ram = 1'b1;
                state_next       = ST_RESP;
            end
            ST_RESP:
            begin
                // The result register takes the new transaction once it is free.
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Response valid follows the result register.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    // State and valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/ac8_datapath.sv
// Datapath of the 8-bit accumulator CPU: registers, ALU, I/O store and main memory.
module ac8_datapath #(
    parameter int MEM_ADDR_BITS = 11,
    parameter int IO_DEPTH      = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    req_operation,
    input  logic [ac8_pkg::ADDR_W-1:0]    req_address,
    input  logic [ac8_pkg::BYTE_W-1:0]    req_data,
    input  ac8_pkg::dp_cmd_t              cmd,
    output ac8_pkg::dp_status_t           status,
    output logic [ac8_pkg::BYTE_W-1:0]    read_data,
    output logic [ac8_pkg::ADDR_W-1:0]    program_counter,
    output logic [ac8_pkg::BYTE_W-1:0]    accumulator,
    output logic [ac8_pkg::BYTE_W-1:0]    memory_buffer,
    output logic [ac8_pkg::BYTE_W-1:0]    io_buffer_reg,
    output logic [ac8_pkg::BYTE_W-1:0]    flag_bits,
    output logic                          halted
);

    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
    localparam int IO_AW     = $clog2(IO_DEPTH);

    // Architectural state.
    logic [MEM_ADDR_BITS-1:0] pc_reg;
    logic [7:0]               acc_reg;
    logic [7:0]               mbr_reg;
    logic [7:0]               iobr_reg;
    logic [7:0]               flag_reg;
    logic                     halt_reg;
    logic [7:0]               io_store_reg [IO_DEPTH];

    // Transaction and sequencing registers.
    logic [1:0]               req_op_reg;
    logic [ac8_pkg::ADDR_W-1:0] req_addr_reg;
    logic [7:0]               req_data_reg;
    logic [7:0]               ir_hi_reg;
    logic [7:0]               rd_ram_reg;
    logic [MEM_ADDR_BITS-1:0] clr_addr_reg;

    // Main memory port.
    logic [MEM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]               ram_wdata;
    logic [7:0]               ram_rdata;

    // Decode and execute.
    logic [ac8_pkg::ADDR_W-1:0] operand;
    logic [MEM_ADDR_BITS-1:0] opd_addr;
    logic [IO_AW-1:0]         io_idx;
    logic [MEM_ADDR_BITS-1:0] pc_inc;
    logic [MEM_ADDR_BITS-1:0] pc_plus2;
    ac8_pkg::opcode_t         opcode;
    logic [8:0]               add_sum;
    logic [8:0]               sub_sum;
    logic [15:0]              prod;
    logic [7:0]               sub_flags;
    logic                     take;
    logic [MEM_ADDR_BITS-1:0] pc_x;
    logic [7:0]               acc_x;
    logic [7:0]               mbr_x;
    logic [7:0]               iobr_x;
    logic [7:0]               flag_x;
    logic                     halt_x;
    logic                     io_we;
    logic [7:0]               rd_out;

    function automatic logic [7:0] make_flags(input logic ovf, input logic carry,
                                              input logic sign, input logic zero);
        logic [7:0] f;
        f                  = '0;
        f[ac8_pkg::FLAG_O] = ovf;
        f[ac8_pkg::FLAG_C] = carry;
        f[ac8_pkg::FLAG_S] = sign;
        f[ac8_pkg::FLAG_Z] = zero;
        return f;
    endfunction

    assign opcode   = ir_hi_reg[7:3];
    assign operand  = {ir_hi_reg[2:0], ram_rdata};
    assign opd_addr = operand[MEM_ADDR_BITS-1:0];
    assign io_idx   = operand[IO_AW-1:0];
    assign pc_inc   = pc_reg + MEM_ADDR_BITS'(1);
    assign pc_plus2 = pc_reg + MEM_ADDR_BITS'(2);

    assign status.halted     = halt_reg;
    assign status.opcode     = opcode;
    assign status.clear_last = &clr_addr_reg;

    // Memory address and write data selection.
    always_comb
    begin
        case (cmd.addr_sel)
            ac8_pkg::ADDR_PC:      ram_addr = pc_reg;
            ac8_pkg::ADDR_PC_INC:  ram_addr = pc_inc;
            ac8_pkg::ADDR_OPERAND: ram_addr = opd_addr;
            ac8_pkg::ADDR_REQ:     ram_addr = req_addr_reg[MEM_ADDR_BITS-1:0];
            ac8_pkg::ADDR_CLEAR:   ram_addr = clr_addr_reg;
            default:               ram_addr = pc_reg;
        endcase
        case (cmd.wdata_sel)
            ac8_pkg::WDATA_REQ:  ram_wdata = req_data_reg;
            ac8_pkg::WDATA_MBR:  ram_wdata = mbr_reg;
            ac8_pkg::WDATA_ZERO: ram_wdata = '0;
            default:             ram_wdata = '0;
        endcase
    end

    ac8_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.ram_en),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ALU results of the arithmetic opcodes; the subtraction is shared with the conditional branches.
    always_comb
    begin
        add_sum   = {1'b0, acc_reg} + {1'b0, mbr_reg};
        sub_sum   = {1'b0, acc_reg} + {1'b0, 8'(~mbr_reg + 8'd1)};
        prod      = 16'(acc_reg) * 16'(mbr_reg);
        sub_flags = make_flags((acc_reg[7] != mbr_reg[7]) && (acc_reg[7] != sub_sum[7]),
                               sub_sum[8], sub_sum[7], sub_sum[7:0] == 8'd0);
    end

    // Instruction execution: next values of the architectural registers.
    always_comb
    begin
        pc_x   = pc_plus2;
        acc_x  = acc_reg;
        mbr_x  = mbr_reg;
        iobr_x = iobr_reg;
        flag_x = flag_reg;
        halt_x = halt_reg;
        io_we  = 1'b0;
        take   = 1'b0;
        case (opcode)
            ac8_pkg::OPC_BR:   pc_x   = opd_addr;
            ac8_pkg::OPC_RIO:  iobr_x = io_store_reg[io_idx];
            ac8_pkg::OPC_WIO:  io_we  = 1'b1;
            ac8_pkg::OPC_WB:   mbr_x  = operand[7:0];
            ac8_pkg::OPC_WIB:  iobr_x = operand[7:0];
            ac8_pkg::OPC_WACC: acc_x  = mbr_reg;
            ac8_pkg::OPC_RACC: mbr_x  = acc_reg;
            ac8_pkg::OPC_SWAP:
            begin
                mbr_x  = iobr_reg;
                iobr_x = mbr_reg;
            end
            ac8_pkg::OPC_ADD:
            begin
                acc_x  = add_sum[7:0];
                flag_x = make_flags((acc_reg[7] == mbr_reg[7]) && (acc_reg[7] != add_sum[7]),
                                    add_sum[8], add_sum[7], add_sum[7:0] == 8'd0);
            end
            ac8_pkg::OPC_SUB:
            begin
                acc_x  = sub_sum[7:0];
                flag_x = sub_flags;
            end
            ac8_pkg::OPC_MUL:
            begin
                acc_x  = prod[7:0];
                flag_x = make_flags(|prod[15:8], |prod[15:8], prod[7], prod[7:0] == 8'd0);
            end
            ac8_pkg::OPC_AND:
            begin
                acc_x  = acc_reg & mbr_reg;
                flag_x = make_flags(1'b0, 1'b0, acc_x[7], acc_x == 8'd0);
            end
            ac8_pkg::OPC_OR:
            begin
                acc_x  = acc_reg | mbr_reg;
                flag_x = make_flags(1'b0, 1'b0, acc_x[7], acc_x == 8'd0);
            end
            ac8_pkg::OPC_NOT:
            begin
                acc_x  = ~acc_reg;
                flag_x = make_flags(1'b0, 1'b0, acc_x[7], acc_x == 8'd0);
            end
            ac8_pkg::OPC_XOR:
            begin
                acc_x  = acc_reg ^ mbr_reg;
                flag_x = make_flags(1'b0, 1'b0, acc_x[7], acc_x == 8'd0);
            end
            ac8_pkg::OPC_SHL:
            begin
                acc_x  = {acc_reg[6:0], 1'b0};
                flag_x = make_flags(1'b0, acc_reg[7], acc_reg[6], acc_reg[6:0] == 7'd0);
            end
            ac8_pkg::OPC_SHR:
            begin
                acc_x  = {1'b0, acc_reg[7:1]};
                flag_x = make_flags(1'b0, acc_reg[0], 1'b0, acc_reg[7:1] == 7'd0);
            end
            ac8_pkg::OPC_BRE, ac8_pkg::OPC_BRNE, ac8_pkg::OPC_BRGT, ac8_pkg::OPC_BRLT:
            begin
                // Compare by subtraction, then branch on the new flags.
                acc_x  = sub_sum[7:0];
                flag_x = sub_flags;
                case (opcode)
                    ac8_pkg::OPC_BRE:  take = sub_flags[ac8_pkg::FLAG_Z];
                    ac8_pkg::OPC_BRNE: take = !sub_flags[ac8_pkg::FLAG_Z];
                    ac8_pkg::OPC_BRGT: take = !sub_flags[ac8_pkg::FLAG_S];
                    default:           take = sub_flags[ac8_pkg::FLAG_S];
                endcase
                if (take)
                begin
                    pc_x = opd_addr;
                end
            end
            ac8_pkg::OPC_EOP:  halt_x = 1'b1;
            default:
            begin
                // Memory moves go through the RAM port; unknown opcodes only advance PC.
                pc_x = pc_plus2;
            end
        endcase
    end

    // Architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            acc_reg  <= '0;
            mbr_reg  <= '0;
            iobr_reg <= '0;
            flag_reg <= '0;
            halt_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            pc_reg   <= pc_x;
            acc_reg  <= acc_x;
            mbr_reg  <= mbr_x;
            iobr_reg <= iobr_x;
            flag_reg <= flag_x;
            halt_reg <= halt_x;
        end
        else if (cmd.mbr_load_ram)
        begin
            mbr_reg <= ram_rdata;
        end
    end

    // I/O store, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < IO_DEPTH; i++)
            begin
                io_store_reg[i] <= '0;
            end
        end
        else if (cmd.exec && io_we)
        begin
            io_store_reg[io_idx] <= iobr_reg;
        end
    end

    // Clearing sweep address for the main memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + MEM_ADDR_BITS'(1);
        end
    end

    // Read data of the finished transaction.
    always_comb
    begin
        case (req_op_reg)
            ac8_pkg::OP_MEM_RD: rd_out = rd_ram_reg;
            ac8_pkg::OP_IO_RD:  rd_out = io_store_reg[req_addr_reg[IO_AW-1:0]];
            default:            rd_out = '0;
        endcase
    end

    // Request capture, fetch and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg   <= req_operation;
            req_addr_reg <= req_address;
            req_data_reg <= req_data;
        end
        if (cmd.ir_hi_load)
        begin
            ir_hi_reg <= ram_rdata;
        end
        if (cmd.rd_load)
        begin
            rd_ram_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            read_data       <= rd_out;
            program_counter <= ac8_pkg::ADDR_W'(pc_reg);
            accumulator     <= acc_reg;
            memory_buffer   <= mbr_reg;
            io_buffer_reg   <= iobr_reg;
            flag_bits       <= flag_reg;
            halted          <= halt_reg;
        end
    end

endmodule

// File: rtl/core/ac8_checker.sv
// Port-level assertions for the 8-bit accumulator CPU, bound to the top level.
module ac8_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [ac8_pkg::BYTE_W-1:0] read_data,
    input logic [ac8_pkg::ADDR_W-1:0] program_counter,
    input logic [ac8_pkg::BYTE_W-1:0] accumulator,
    input logic [ac8_pkg::BYTE_W-1:0] memory_buffer,
    input logic [ac8_pkg::BYTE_W-1:0] io_buffer_reg,
    input logic [ac8_pkg::BYTE_W-1:0] flag_bits,
    input logic                       halted
);

    logic                       req_acc;
    logic                       rsp_acc;
    logic [1:0]                 pending_reg;
    logic                       halt_seen_reg;
    logic [ac8_pkg::ADDR_W-1:0] halt_pc_reg;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Requests in flight and the state seen at the first halted response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            halt_seen_reg <= 1'b0;
            halt_pc_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(req_acc) - 2'(rsp_acc);
            if (rsp_acc && halted && !halt_seen_reg)
            begin
                halt_seen_reg <= 1'b1;
                halt_pc_reg   <= program_counter;
            end
        end
    end

    // A stalled response transaction keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({read_data, program_counter,
        accumulator, memory_buffer, io_buffer_reg, flag_bits, halted}))
        else $error("response payload changed while stalled");

    // No response without an outstanding request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without an outstanding request");

    // At most one request in work and one result waiting.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many requests in flight");

    // Halt is sticky.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && halt_seen_reg |-> halted)
        else $error("halted cleared without reset");

    // Once halted, the program counter no longer moves.
    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && halt_seen_reg |-> program_counter == halt_pc_reg)
        else $error("program counter moved after halt");

endmodule

bind accumulator_cpu_8bit ac8_checker u_ac8_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .read_data       (rsp.read_data),
    .program_counter (rsp.program_counter),
    .accumulator     (rsp.accumulator),
    .memory_buffer   (rsp.memory_buffer),
    .io_buffer_reg   (rsp.io_buffer_reg),
    .flag_bits       (rsp.flag_bits),
    .halted          (rsp.halted)
);
